// File: hw/rtl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared types and constants for the shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

    localparam int VALUE_W = 31;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = VALUE_W + MULT_W;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
    // modulus minus one, used to size the table index divisor
    localparam int LCG_MOD_M1   = 2147483646;
    localparam int WARMUP_EXTRA = 8;

endpackage

`default_nettype wire

// File: hw/rtl/shuffled_lehmer_random_generator_top.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_top
// Minimal-standard Lehmer generator feeding a Bays-Durham shuffle table.
//
// Request channel: req_valid / req_stall carry action and seed_value. The
// block takes a request only when idle; req_stall stays high while one is
// being worked on. Response channel: rsp_valid / rsp_stall carry one
// random_value per request, held in an output register.
// A draw after acceptance runs the table index by a reciprocal
// multiply, the table read with the next generator value, then the swap
// into the output register; the next request waits for the swap.
// A reseed, or the first draw after reset, adds a warmup that steps
// the generator and loads the table; each warmup step uses the
// registered multiplier in S_SEED_MUL and the modular fold in S_SEED_RED.
// Reset leaves the generator unseeded; the first draw seeds with 1.
// A stalled response holds its value; the block may accept the next
// request meanwhile and waits before the table swap until the output
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lehmer_random_generator_top #(
    parameter int TABLE_SIZE = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire logic            action,
    input  wire slrg_pkg::value_t seed_value,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output slrg_pkg::value_t     random_value
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + slrg_pkg::WARMUP_EXTRA);
    localparam int IDX_DIV = 1 + (slrg_pkg::LCG_MOD_M1 / TABLE_SIZE);
    // reciprocal of the index divisor, exact for every 31-bit shuffle value
    localparam int RECIP_SHIFT = slrg_pkg::VALUE_W + $clog2(IDX_DIV);
    localparam logic [31:0] RECIP =
        32'(((64'd1 << RECIP_SHIFT) + 64'(IDX_DIV) - 64'd1) / 64'(IDX_DIV));
    localparam logic [CNT_W-1:0] WARM_LAST =
        CNT_W'(TABLE_SIZE + slrg_pkg::WARMUP_EXTRA - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEED_MUL = 3'd1;
    localparam logic [2:0] S_SEED_RED = 3'd2;
    localparam logic [2:0] S_DRAW     = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;
    localparam logic [2:0] S_SWAP     = 3'd5;

    logic [2:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    slrg_pkg::value_t x_reg;
    slrg_pkg::value_t x_next;
    slrg_pkg::value_t shuffle_reg;
    logic [62:0]      idx_prod_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rsp_valid_reg;
    slrg_pkg::value_t rsp_value_reg;

    slrg_pkg::value_t table_mem [TABLE_SIZE];
    slrg_pkg::value_t rd_data_reg;

    logic             req_accept;
    logic             out_free;
    slrg_pkg::value_t seed_start;
    logic [IDX_W-1:0] idx_raw;
    logic [IDX_W-1:0] idx_clamped;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slrg_pkg::value_t wr_data;

    slrg_lehmer_step u_step (
        .clk    (clk),
        .x      (x_reg),
        .x_next (x_next)
    );

    assign req_stall    = (state_reg != S_IDLE);
    assign req_accept   = req_valid && !req_stall;
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign random_value = rsp_value_reg;

    // zero and the modulus itself both reduce to a zero seed, taken as 1
    assign seed_start = ((seed_value == '0) || (seed_value == slrg_pkg::LCG_MOD))
                      ? slrg_pkg::VALUE_W'(1) : seed_value;

    assign idx_raw     = IDX_W'(idx_prod_reg >> RECIP_SHIFT);
    assign idx_clamped = ((IDX_W+1)'(idx_raw) >= (IDX_W+1)'(TABLE_SIZE))
                       ? IDX_W'(TABLE_SIZE - 1) : idx_raw;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = x_reg;
        if ((state_reg == S_SEED_RED) && (cnt_reg < CNT_W'(TABLE_SIZE)))
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[IDX_W-1:0];
            wr_data = x_next;
        end
        else if ((state_reg == S_SWAP) && out_free)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= table_mem[idx_clamped];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            x_reg         <= slrg_pkg::VALUE_W'(1);
            shuffle_reg   <= '0;
            idx_prod_reg  <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_value_reg <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_SWAP))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        if (action)
                        begin
                            x_reg     <= seed_start;
                            cnt_reg   <= WARM_LAST;
                            state_reg <= S_SEED_MUL;
                        end
                        else if (shuffle_reg == '0)
                        begin
                            x_reg     <= slrg_pkg::VALUE_W'(1);
                            cnt_reg   <= WARM_LAST;
                            state_reg <= S_SEED_MUL;
                        end
                        else
                        begin
                            state_reg <= S_DRAW;
                        end
                    end
                end
                S_SEED_MUL:
                begin
                    state_reg <= S_SEED_RED;
                end
                S_SEED_RED:
                begin
                    x_reg <= x_next;
                    if (cnt_reg == '0)
                    begin
                        // entry 0 is the last value loaded
                        shuffle_reg <= x_next;
                        state_reg   <= S_DRAW;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - CNT_W'(1);
                        state_reg <= S_SEED_MUL;
                    end
                end
                S_DRAW:
                begin
                    // table index as a multiply by the divisor's reciprocal
                    idx_prod_reg <= 63'(shuffle_reg) * 63'(RECIP);
                    state_reg    <= S_READ;
                end
                S_READ:
                begin
                    idx_reg   <= idx_clamped;
                    x_reg     <= x_next;
                    state_reg <= S_SWAP;
                end
                S_SWAP:
                begin
                    if (out_free)
                    begin
                        shuffle_reg   <= rd_data_reg;
                        rsp_value_reg <= rd_data_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a response appears only out of the table swap
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_SWAP))
        else $error("response raised outside the table swap");

    // the draw never starts unseeded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW) |-> (shuffle_reg != '0))
        else $error("draw started with an unseeded shuffle value");

    // the generator state never collapses to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        x_reg != '0)
        else $error("lehmer state reached zero");

    // a swap must not overwrite a response still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> $stable(rsp_value_reg))
        else $error("pending response overwritten");

    // the table index stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP) |-> ((IDX_W+1)'(idx_reg) < (IDX_W+1)'(TABLE_SIZE)))
        else $error("table index out of range");

endmodule

`default_nettype wire

// File: hw/rtl/slrg_lehmer_step.sv
// ----------------------------------------------------------------------------
// slrg_lehmer_step
// One minimal-standard step x' = 16807 * x mod (2^31 - 1); the product is
// registered, and the folded reduction is combinational from that register.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_lehmer_step (
    input  wire logic            clk,
    input  wire slrg_pkg::value_t x,
    output slrg_pkg::value_t     x_next
);

    slrg_pkg::prod_t prod_reg;
    logic [slrg_pkg::VALUE_W:0] fold_sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= slrg_pkg::PROD_W'(x) * slrg_pkg::PROD_W'(slrg_pkg::LCG_MULT);
    end

    // 2^31 == 1 mod m, so high part folds onto the low part
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[slrg_pkg::VALUE_W-1:0]}
                 + (slrg_pkg::VALUE_W+1)'(prod_reg[slrg_pkg::PROD_W-1:slrg_pkg::VALUE_W]);
        if (fold_sum >= {1'b0, slrg_pkg::LCG_MOD})
        begin
            x_next = slrg_pkg::VALUE_W'(fold_sum - {1'b0, slrg_pkg::LCG_MOD});
        end
        else
        begin
            x_next = fold_sum[slrg_pkg::VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: tb/slrg_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slrg_tb_pkg
// Request codes shared by the generator testbench and its checker.
// ----------------------------------------------------------------------------

package slrg_tb_pkg;

    typedef enum logic {
        ACT_DRAW   = 1'b0,
        ACT_RESEED = 1'b1
    } action_e;

endpackage

// File: tb/slrg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slrg_checker
// Watches both channels of the shuffled Lehmer generator, keeps its own
// generator state and shuffle table, predicts each random_value and
// compares it with the response in order.
// ----------------------------------------------------------------------------

module slrg_checker
    import slrg_pkg::*;
    import slrg_tb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    input  logic   req_stall,
    input  logic   action,
    input  value_t seed_value,
    input  logic   rsp_valid,
    input  logic   rsp_stall,
    input  value_t random_value,
    output int     fail_count,
    output int     pending_count
);

    localparam int TABLE_SIZE = 32;
    localparam longint unsigned INDEX_DIV = 1 + LCG_MOD_M1 / TABLE_SIZE;

    value_t gen_state;
    value_t shuffle_state;
    value_t shuffle_table [TABLE_SIZE];
    value_t expected_values [$];

    function automatic value_t lehmer_step(input value_t x);
        longint unsigned prod;
        prod = 64'(x);
        prod = prod * LCG_MULT;
        return value_t'(prod % LCG_MOD);
    endfunction

    task automatic reseed_generator(input value_t seed);
        value_t x;
        x = (seed == LCG_MOD) ? '0 : seed;
        if (x == '0)
            x = value_t'(1);
        for (int j = TABLE_SIZE + WARMUP_EXTRA - 1; j >= 0; j--)
        begin
            x = lehmer_step(x);
            if (j < TABLE_SIZE)
                shuffle_table[j] = x;
        end
        gen_state     = x;
        shuffle_state = shuffle_table[0];
    endtask

    task automatic predict_draw(input logic act, input value_t seed, output value_t result);
        longint unsigned idx;
        if (action_e'(act) == ACT_RESEED)
            reseed_generator(seed);
        else if (shuffle_state == '0)
            reseed_generator(value_t'(1));
        gen_state = lehmer_step(gen_state);
        idx = shuffle_state / INDEX_DIV;
        if (idx >= TABLE_SIZE)
            idx = 64'(TABLE_SIZE - 1);
        result             = shuffle_table[idx];
        shuffle_state      = result;
        shuffle_table[idx] = gen_state;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        value_t want;
        if (!rst_n)
        begin
            gen_state     = value_t'(1);
            shuffle_state = '0;
            foreach (shuffle_table[i])
                shuffle_table[i] = '0;
            expected_values.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // responses are registered, so pop before taking this edge's request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("random_value: expected none, actual %0d", random_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (random_value !== want)
                    begin
                        $error("random_value: expected %0d, actual %0d", want, random_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_draw(action, seed_value, want);
                expected_values.push_back(want);
            end
            pending_count <= expected_values.size();
        end
    end

endmodule

// File: tb/shuffled_lehmer_random_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_top_tb
// Drives draw and reseed requests into the shuffled Lehmer generator under
// three idle/stall mixes and reports the verdict from the checker.
// ----------------------------------------------------------------------------

module shuffled_lehmer_random_generator_top_tb;

    import slrg_pkg::*;
    import slrg_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int DRAIN_CYCLES    = 40;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   req_valid;
    logic   req_stall;
    logic   action;
    value_t seed_value;
    logic   rsp_valid;
    logic   rsp_stall = 1'b0;
    value_t random_value;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int pending_count;

    shuffled_lehmer_random_generator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .seed_value   (seed_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .random_value (random_value)
    );

    slrg_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .action        (action),
        .seed_value    (seed_value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .random_value  (random_value),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic issue_request(input action_e act, input value_t seed);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            // payload is don't-care while idle
            req_valid  <= 1'b0;
            action     <= 1'($urandom_range(0, 1));
            seed_value <= value_t'($urandom);
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        action     <= act;
        seed_value <= seed;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    function automatic value_t pick_seed();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return LCG_MOD;
            2:       return LCG_MOD - value_t'(1);
            3:       return value_t'(1);
            default: return value_t'($urandom);
        endcase
    endfunction

    initial
    begin
        req_valid      <= 1'b0;
        action         <= ACT_DRAW;
        seed_value     <= '0;
        rst_n          <= 1'b0;
        send_idle_pct  = 21;
        recv_stall_pct = 80;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draw before any seed, then the seed edge cases
        issue_request(ACT_DRAW, LCG_MOD);
        issue_request(ACT_DRAW, '0);
        issue_request(ACT_DRAW, 31'h2AAA_AAAA);
        issue_request(ACT_RESEED, '0);
        issue_request(ACT_DRAW, 31'h5555_5555);
        issue_request(ACT_RESEED, LCG_MOD);
        issue_request(ACT_DRAW, '0);
        issue_request(ACT_RESEED, value_t'(1));
        issue_request(ACT_DRAW, LCG_MOD);
        issue_request(ACT_RESEED, LCG_MOD - value_t'(1));
        issue_request(ACT_DRAW, '0);
        issue_request(ACT_DRAW, '0);
        issue_request(ACT_RESEED, 31'h5555_5555);
        issue_request(ACT_DRAW, '0);
        issue_request(ACT_RESEED, 31'h2AAA_AAAA);
        issue_request(ACT_RESEED, 31'h4000_0000);
        issue_request(ACT_DRAW, LCG_MOD);
        issue_request(ACT_DRAW, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == RANDOM_REQUESTS / 3)
            begin
                send_idle_pct  = 80;
                recv_stall_pct = 21;
            end
            else if (n == 2 * RANDOM_REQUESTS / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // mostly long draw runs, with an occasional reseed
            if ($urandom_range(0, 15) == 0)
                issue_request(ACT_RESEED, pick_seed());
            else
                issue_request(ACT_DRAW, value_t'($urandom));
        end
        req_valid      <= 1'b0;
        recv_stall_pct = 0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
